### hw/rtl/rdsm_pkg.sv
// Shared types and constants for the dot-star regular expression matcher.
`timescale 1ns / 1ps

package rdsm_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int CHAR_W = 8;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W = $clog2(MAX_TOKENS + 1);
  localparam logic [CHAR_W-1:0] ANY_CHAR = 8'd46;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LOW  = 2'd0,
    REG_CHARS_HIGH = 2'd1,
    REG_STAR_MASK  = 2'd2,
    REG_TOKEN_CNT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic carry;
    logic adv;
  } link_t;

  typedef struct packed {
    logic matched;
    logic final_verdict;
  } result_t;

endpackage

### hw/rtl/rdsm_cell.sv
// One pattern position of the matcher chain: its active bit, token compare and closure links.
`timescale 1ns / 1ps

module rdsm_cell (
  input  logic                      clk,
  input  logic                      step,
  input  logic                      fresh,
  input  logic                      en,
  input  logic                      star,
  input  logic [rdsm_pkg::CHAR_W-1:0] tok_char,
  input  logic [rdsm_pkg::CHAR_W-1:0] text_char,
  input  rdsm_pkg::link_t           link_in,
  output rdsm_pkg::link_t           link_out,
  output logic                      eff,
  output logic                      nxt
);
  import rdsm_pkg::*;

  logic active;
  logic hit;

  assign eff = fresh ? link_in.start : active;
  assign hit = eff & en & ((tok_char == ANY_CHAR) | (tok_char == text_char));
  assign nxt = (hit & star) | link_in.adv | link_in.carry;

  assign link_out.start = link_in.start & star & en;
  assign link_out.carry = nxt & star & en;
  assign link_out.adv   = hit & ~star;

  always_ff @(posedge clk) begin
    if (step) begin
      active <= nxt;
    end
  end

endmodule

### hw/rtl/rdsm_out_buf.sv
// Two-entry output buffer that keeps the input side open while a result waits.
`timescale 1ns / 1ps

module rdsm_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rdsm_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output rdsm_pkg::result_t out_data
);
  import rdsm_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign pop = out_valid & out_ready;
  assign can_push = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/regex_dot_star_matcher.sv
// Top level of the streaming whole-string matcher for literal, dot and star patterns.
`timescale 1ns / 1ps

// The matcher takes one text character per cycle and returns one result per character,
// so a new transfer is taken every cycle while the output side keeps up. Each pattern
// position is a cell in a chain; the star closure ripples through the chain within the
// same cycle, and each result is registered. An end marker returns the final verdict and
// rearms the matcher, as does any register write, so the next string may follow at once.
// The user must write registers only while the block is idle; nothing enforces it.
module regex_dot_star_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rdsm_pkg::CHAR_W-1:0]    text_char,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          matched,
  output logic                          final_verdict,
  input  logic                          cfg_we,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdsm_pkg::CFG_W-1:0]     cfg_data
);
  import rdsm_pkg::*;

  logic [CFG_W-1:0]       token_chars_low;
  logic [CFG_W-1:0]       token_chars_high;
  logic [MAX_TOKENS-1:0]  star_mask;
  logic [4:0]             token_count;
  logic                   fresh;
  logic                   active_last;

  logic [COUNT_W-1:0]     n_used;
  logic [2*CFG_W-1:0]     all_chars;
  logic [MAX_TOKENS:0]    eff;
  logic [MAX_TOKENS:0]    nxt;
  link_t                  link [MAX_TOKENS+1];
  logic                   accept;
  logic                   step;
  result_t                res;
  result_t                out_res;

  assign n_used = (token_count > 5'(MAX_TOKENS)) ? COUNT_W'(MAX_TOKENS)
                                                  : COUNT_W'(token_count);
  assign all_chars = {token_chars_high, token_chars_low};
  assign link[0] = '{start: 1'b1, carry: 1'b0, adv: 1'b0};

  assign accept = in_valid & in_ready;
  assign step = accept & ~end_of_text;

  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    rdsm_cell u_cell (
      .clk       (clk),
      .step      (step),
      .fresh     (fresh),
      .en        (COUNT_W'(i) < n_used),
      .star      (star_mask[i]),
      .tok_char  (all_chars[CHAR_W*i +: CHAR_W]),
      .text_char (text_char),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .eff       (eff[i]),
      .nxt       (nxt[i])
    );
  end

  assign eff[MAX_TOKENS] = fresh ? link[MAX_TOKENS].start : active_last;
  assign nxt[MAX_TOKENS] = link[MAX_TOKENS].adv | link[MAX_TOKENS].carry;

  assign res.matched = end_of_text ? eff[n_used] : nxt[n_used];
  assign res.final_verdict = end_of_text;

  always_ff @(posedge clk) begin
    if (step) begin
      active_last <= nxt[MAX_TOKENS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_chars_low  <= '0;
      token_chars_high <= '0;
      star_mask        <= '0;
      token_count      <= '0;
      fresh            <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHARS_LOW:  token_chars_low  <= cfg_data;
          REG_CHARS_HIGH: token_chars_high <= cfg_data;
          REG_STAR_MASK:  star_mask        <= cfg_data[MAX_TOKENS-1:0];
          REG_TOKEN_CNT:  token_count      <= cfg_data[4:0];
        endcase
        fresh <= 1'b1;
      end else if (accept) begin
        fresh <= end_of_text;
      end
    end
  end

  rdsm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign matched = out_res.matched;
  assign final_verdict = out_res.final_verdict;

endmodule
